FILE: rtl/core/pcpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared widths and the front-to-back record of the clash penalty core.
// ----------------------------------------------------------------------------
package pcpa_pkg;
  localparam int COORD_W   = 32;
  localparam int RAD_W     = 20;
  localparam int ACC_W     = 48;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAG_W     = RAD_W;       // |e| < c keeps magnitudes in 20 bits
  localparam int SQ_W      = 2 * RAD_W + 2;
  localparam int QDEPTH    = 4;

  // Classified pair handed from the front to the back.
  typedef struct packed {
    logic             hit;     // pair overlaps
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] az;
    logic             nx;      // e > 0 on that axis
    logic             ny;
    logic             nz;
    logic [RAD_W-1:0] c;
    logic [SQ_W-1:0]  s;
    logic             last;
  } pair_t;
endpackage
`default_nettype wire

FILE: rtl/core/pcpa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_in_if / pcpa_out_if
// Valid/ready channels for pairs and results.
// ----------------------------------------------------------------------------
interface pcpa_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] atom_x;
  logic signed [31:0] atom_y;
  logic signed [31:0] atom_z;
  logic signed [31:0] partner_x;
  logic signed [31:0] partner_y;
  logic signed [31:0] partner_z;
  logic [19:0] radius_sum;
  logic last_pair;
  modport source (output valid, atom_x, atom_y, atom_z, partner_x, partner_y,
                  partner_z, radius_sum, last_pair, input ready);
  modport sink (input valid, atom_x, atom_y, atom_z, partner_x, partner_y,
                partner_z, radius_sum, last_pair, output ready);
endinterface

interface pcpa_out_if;
  logic valid;
  logic ready;
  logic [47:0] clash_loss;
  logic signed [47:0] grad_x;
  logic signed [47:0] grad_y;
  logic signed [47:0] grad_z;
  logic zero_distance_seen;
  logic saturated;
  modport source (output valid, clash_loss, grad_x, grad_y, grad_z,
                  zero_distance_seen, saturated, input ready);
  modport sink (input valid, clash_loss, grad_x, grad_y, grad_z,
                zero_distance_seen, saturated, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pcpa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_front
// Takes pairs, forms differences and squared distance, classifies overlap.
// Two register stages; a credit count keeps the queue from overflowing.
// ----------------------------------------------------------------------------
module pcpa_front (
  input  wire logic clk,
  input  wire logic rst_n,
  pcpa_in_if.sink   in_ch,
  output pcpa_pkg::pair_t q_data,
  output logic      q_push,
  input  wire logic q_pop
);
  import pcpa_pkg::*;

  localparam int CW = $clog2(QDEPTH + 1);

  logic [CW-1:0] cred_r, cred_nxt;
  logic          v1_r, v2_r;
  logic [MAG_W-1:0] ax1_r, ay1_r, az1_r;
  logic          nx1_r, ny1_r, nz1_r, near1_r, last1_r;
  logic [RAD_W-1:0] c1_r;
  pair_t         p2_r;

  logic signed [COORD_W:0] ex, ey, ez;
  logic [COORD_W:0] mx, my, mz;
  logic near;
  logic acc;
  logic [2*MAG_W-1:0] sqx, sqy, sqz;
  logic [2*RAD_W-1:0] sqc;
  logic [SQ_W-1:0]    s1;

  // Slots in use: in flight plus queued; pops return a slot.
  assign in_ch.ready = (cred_r < CW'(QDEPTH));
  assign acc = in_ch.valid && in_ch.ready;
  always_comb begin
    cred_nxt = cred_r;
    if (acc && !q_pop) cred_nxt = cred_r + 1'b1;
    else if (!acc && q_pop) cred_nxt = cred_r - 1'b1;
  end

  // Stage 1: differences and magnitudes
  assign ex = {in_ch.atom_x[31], in_ch.atom_x} - {in_ch.partner_x[31], in_ch.partner_x};
  assign ey = {in_ch.atom_y[31], in_ch.atom_y} - {in_ch.partner_y[31], in_ch.partner_y};
  assign ez = {in_ch.atom_z[31], in_ch.atom_z} - {in_ch.partner_z[31], in_ch.partner_z};
  assign mx = ex[COORD_W] ? (COORD_W+1)'(-ex) : ex;
  assign my = ey[COORD_W] ? (COORD_W+1)'(-ey) : ey;
  assign mz = ez[COORD_W] ? (COORD_W+1)'(-ez) : ez;
  assign near = (mx < (COORD_W+1)'(in_ch.radius_sum)) &&
                (my < (COORD_W+1)'(in_ch.radius_sum)) &&
                (mz < (COORD_W+1)'(in_ch.radius_sum));

  // Stage 2 squares, full width products
  assign sqx = ax1_r * ax1_r;
  assign sqy = ay1_r * ay1_r;
  assign sqz = az1_r * az1_r;
  assign sqc = c1_r * c1_r;
  assign s1  = SQ_W'(sqx) + SQ_W'(sqy) + SQ_W'(sqz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      cred_r <= cred_nxt;
      v1_r   <= acc;
      v2_r   <= v1_r;
    end
    ax1_r <= mx[MAG_W-1:0];
    ay1_r <= my[MAG_W-1:0];
    az1_r <= mz[MAG_W-1:0];
    nx1_r <= !ex[COORD_W] && (ex != '0);
    ny1_r <= !ey[COORD_W] && (ey != '0);
    nz1_r <= !ez[COORD_W] && (ez != '0);
    near1_r <= near;
    c1_r    <= in_ch.radius_sum;
    last1_r <= in_ch.last_pair;
    // Stage 2: squared distance against c squared
    p2_r.ax <= ax1_r;
    p2_r.ay <= ay1_r;
    p2_r.az <= az1_r;
    p2_r.nx <= nx1_r;
    p2_r.ny <= ny1_r;
    p2_r.nz <= nz1_r;
    p2_r.c  <= c1_r;
    p2_r.last <= last1_r;
    p2_r.s  <= s1;
    p2_r.hit <= near1_r && (s1 < SQ_W'(sqc));
  end

  assign q_data = p2_r;
  assign q_push = v2_r;
endmodule
`default_nettype wire

FILE: rtl/core/pcpa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_queue
// Small FIFO of classified pairs between front and back.
// ----------------------------------------------------------------------------
module pcpa_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire pcpa_pkg::pair_t wr_data,
  input  wire logic push,
  output pcpa_pkg::pair_t rd_data,
  output logic      not_empty,
  input  wire logic pop
);
  import pcpa_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  pair_t        mem_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

FILE: rtl/core/pcpa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_back
// Per pair: bit-serial square root, loss term, three serial divisions,
// saturating accumulation and result hand-off.
// ----------------------------------------------------------------------------
module pcpa_back #(
  parameter int FRAC_BITS = pcpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire pcpa_pkg::pair_t q_data,
  input  wire logic q_valid,
  output logic      q_pop,
  pcpa_out_if.source out_ch
);
  import pcpa_pkg::*;

  localparam int RW  = SQ_W / 2;           // root width
  localparam int NW  = RAD_W + MAG_W + 1;  // 2*v*|e| numerator
  localparam int SCW = $clog2(NW + 1);
  localparam logic [ACC_W-1:0] LMAX = '1;
  localparam logic signed [ACC_W+1:0] GMAX = (ACC_W+2)'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [ACC_W+1:0] GMIN = -GMAX - 1;

  typedef enum logic [2:0] {S_IDLE, S_SQRT, S_LOSS, S_DIV, S_ACC, S_OUT} st_t;

  st_t st_r;
  pair_t p_r;
  logic [SQ_W-1:0] rem_r;
  logic [RW+1:0]   root_r;
  logic [SCW-1:0]  cnt_r;
  logic [1:0]      ax_r;
  logic [RAD_W-1:0] v_r;
  logic [NW-1:0]   num_r;
  logic [RW:0]     drem_r;
  logic [NW-1:0]   qx_r, qy_r, qz_r;
  logic [ACC_W-1:0] loss_r;
  logic signed [ACC_W-1:0] gx_r, gy_r, gz_r;
  logic zf_r, sf_r;

  logic [RW+1:0]   d;
  logic [RW+1:0]   dtrial;
  logic [RW+1:0]   dsh;
  logic [2*RAD_W-1:0] vsq;
  logic [ACC_W:0]  lsum;
  logic [MAG_W-1:0] amag;
  logic [NW-1:0]   num0;
  logic signed [ACC_W+1:0] tx, ty, tz;

  assign d = root_r;
  assign dsh = {drem_r, num_r[NW-1]};
  assign dtrial = dsh - d;
  assign vsq = v_r * v_r;
  assign lsum = {1'b0, loss_r} + (ACC_W+1)'(vsq >> FRAC_BITS);
  assign amag = (ax_r == 2'd0) ? p_r.ax : (ax_r == 2'd1) ? p_r.ay : p_r.az;
  assign num0 = {v_r, 1'b0} * amag;
  assign tx = p_r.nx ? {gx_r[ACC_W-1], gx_r[ACC_W-1], gx_r} - (ACC_W+2)'(qx_r)
                     : {gx_r[ACC_W-1], gx_r[ACC_W-1], gx_r} + (ACC_W+2)'(qx_r);
  assign ty = p_r.ny ? {gy_r[ACC_W-1], gy_r[ACC_W-1], gy_r} - (ACC_W+2)'(qy_r)
                     : {gy_r[ACC_W-1], gy_r[ACC_W-1], gy_r} + (ACC_W+2)'(qy_r);
  assign tz = p_r.nz ? {gz_r[ACC_W-1], gz_r[ACC_W-1], gz_r} - (ACC_W+2)'(qz_r)
                     : {gz_r[ACC_W-1], gz_r[ACC_W-1], gz_r} + (ACC_W+2)'(qz_r);

  function automatic logic signed [ACC_W-1:0] clampg(input logic signed [ACC_W+1:0] t);
    if (t > GMAX) return GMAX[ACC_W-1:0];
    if (t < GMIN) return GMIN[ACC_W-1:0];
    return t[ACC_W-1:0];
  endfunction

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.clash_loss = loss_r;
  assign out_ch.grad_x = gx_r;
  assign out_ch.grad_y = gy_r;
  assign out_ch.grad_z = gz_r;
  assign out_ch.zero_distance_seen = zf_r;
  assign out_ch.saturated = sf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      loss_r <= '0;
      gx_r   <= '0;
      gy_r   <= '0;
      gz_r   <= '0;
      zf_r   <= 1'b0;
      sf_r   <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (q_valid) begin
          p_r    <= q_data;
          rem_r  <= q_data.s;
          root_r <= '0;
          drem_r <= '0;
          cnt_r  <= SCW'(RW);
          st_r   <= q_data.hit ? S_SQRT : (q_data.last ? S_OUT : S_IDLE);
        end
        // Root digit by digit: remainder shifts in two bits of s
        S_SQRT: begin
          logic [RW+3:0] rem2;
          logic [RW+3:0] trial;
          rem2  = {drem_r[RW-0:0], p_r.s[2*cnt_r-1 -: 2]};
          trial = {root_r, 2'b01};
          if (rem2 >= trial) begin
            drem_r <= (RW+1)'(rem2 - trial);
            root_r <= {root_r[RW:0], 1'b1};
          end else begin
            drem_r <= (RW+1)'(rem2);
            root_r <= {root_r[RW:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == SCW'(1)) st_r <= S_LOSS;
        end
        S_LOSS: begin
          v_r <= p_r.c - RAD_W'(root_r);
          st_r <= S_DIV;
          ax_r <= 2'd0;
          cnt_r <= '0;
        end
        // Restoring division 2*v*|e| / d, one quotient bit per cycle
        S_DIV: begin
          if (cnt_r == '0) begin
            if (ax_r == 2'd0) begin
              if (lsum > {1'b0, LMAX}) begin
                loss_r <= LMAX;
                sf_r <= 1'b1;
              end else loss_r <= lsum[ACC_W-1:0];
            end
            if (root_r == '0) begin
              zf_r <= 1'b1;
              st_r <= p_r.last ? S_OUT : S_IDLE;
            end
            num_r  <= num0;
            drem_r <= '0;
            cnt_r  <= SCW'(NW);
          end else begin
            if (dsh >= d) begin
              drem_r <= dtrial[RW:0];
              num_r  <= {num_r[NW-2:0], 1'b1};
            end else begin
              drem_r <= dsh[RW:0];
              num_r  <= {num_r[NW-2:0], 1'b0};
            end
            cnt_r <= cnt_r - 1'b1;
            if (cnt_r == SCW'(1)) begin
              if (ax_r == 2'd0) qx_r <= {num_r[NW-2:0], dsh >= d};
              if (ax_r == 2'd1) qy_r <= {num_r[NW-2:0], dsh >= d};
              if (ax_r == 2'd2) begin
                qz_r <= {num_r[NW-2:0], dsh >= d};
                st_r <= S_ACC;
              end
              ax_r <= ax_r + 1'b1;
            end
          end
        end
        S_ACC: begin
          gx_r <= clampg(tx);
          gy_r <= clampg(ty);
          gz_r <= clampg(tz);
          if (tx > GMAX || tx < GMIN || ty > GMAX || ty < GMIN ||
              tz > GMAX || tz < GMIN) sf_r <= 1'b1;
          st_r <= p_r.last ? S_OUT : S_IDLE;
        end
        S_OUT: if (out_ch.ready) begin
          loss_r <= '0;
          gx_r <= '0;
          gy_r <= '0;
          gz_r <= '0;
          zf_r <= 1'b0;
          sf_r <= 1'b0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/pairwise_clash_penalty_accumulator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pairwise_clash_penalty_accumulator_core
// Accumulates squared overlap loss and gradient over a run of atom pairs.
// ----------------------------------------------------------------------------
// Usage: pairs enter on in_ch (valid/ready); one transfer per pair. The pair
// marked last_pair closes the run and a single result transfer appears on
// out_ch with loss, gradient and flags; the sums then clear.
// The front computes differences and squared distance in two stages and pushes
// into a four-entry queue, so it keeps taking pairs while the back works.
// A non-overlapping pair is only popped by the back. An overlapping pair goes
// through a pop, a 21-step serial square root, the overlap, three serial
// divisions of one setup and 41 steps each for the gradient, and an
// accumulate (at zero distance the divisions and accumulate are skipped).
// The serial divider in the back sets sustained throughput.
// Reset (rst_n low, synchronous) clears the queue and all sums.
// When the receiver stalls the result waits in the back's registers; the
// front keeps accepting until the queue fills, then drops in_ch ready.
// ----------------------------------------------------------------------------
module pairwise_clash_penalty_accumulator_core #(
  parameter int FRAC_BITS = pcpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pcpa_in_if.sink    in_ch,
  pcpa_out_if.source out_ch
);
  import pcpa_pkg::*;

  pair_t f_data, q_rd;
  logic  f_push, q_ne, q_pop;

  pcpa_front u_front (.clk, .rst_n, .in_ch, .q_data(f_data), .q_push(f_push),
                      .q_pop);
  pcpa_queue u_queue (.clk, .rst_n, .wr_data(f_data), .push(f_push),
                      .rd_data(q_rd), .not_empty(q_ne), .pop(q_pop));
  pcpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (.clk, .rst_n, .q_data(q_rd),
                      .q_valid(q_ne), .q_pop, .out_ch);
endmodule
`default_nettype wire
